[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("lbl");
`define AST_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("lbl");
`else
`define AST_IMPL(lbl, clk, rst_n, a, b)
`define AST_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

[rtl/core/lobm_pkg.sv]
// Package: codes and types of the order book matcher
package lobm_pkg;
  localparam logic [1:0] MODE_LIMIT    = 2'd0;
  localparam logic [1:0] MODE_MARKET   = 2'd1;
  localparam logic [1:0] MODE_CANCEL   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_MKT_DROP  = 3'd2;
  localparam logic [2:0] ST_FULL_DROP = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_REST, S_CANCEL, S_SUMMARY
  } fsm_t;

  // Command from the sequencer to every cell of one side
  typedef struct packed {
    logic pop;     // shift every entry one place towards the head
    logic dec;     // reduce the head quantity by the trade amount
    logic ins;     // insert the new entry at its sorted place
    logic del;     // remove the first entry matching the id
  } side_cmd_t;
endpackage

[rtl/core/lobm_cell.sv]
// One book entry cell: holds an entry and shifts with its neighbours
module lobm_cell #(
  parameter int PW = 16,
  parameter int QW = 20,
  parameter int IW = 32
) (
  input  logic                clk,
  input  logic                is_bid,
  input  lobm_pkg::side_cmd_t cmd,
  input  logic                occ,       // this place holds an entry
  input  logic                up_ins,    // the insert place lies above this cell
  input  logic                up_hit,    // a cell above already matched the id
  input  logic [PW-1:0]       prev_price,
  input  logic [QW-1:0]       prev_qty,
  input  logic [IW-1:0]       prev_id,
  input  logic [PW-1:0]       next_price,
  input  logic [QW-1:0]       next_qty,
  input  logic [IW-1:0]       next_id,
  input  logic [PW-1:0]       new_price,
  input  logic [QW-1:0]       new_qty,
  input  logic [IW-1:0]       new_id,
  input  logic [QW-1:0]       dec_qty,
  input  logic                is_head,
  output logic                ins_here,  // insert lands at or above here
  output logic                hit_here,  // id matched here or above
  output logic [PW-1:0]       price_r,
  output logic [QW-1:0]       qty_r,
  output logic [IW-1:0]       id_r
);
  logic [PW-1:0] price_nxt;
  logic [QW-1:0] qty_nxt;
  logic [IW-1:0] id_nxt;
  logic          behind;
  logic          my_hit;

  // new entry goes before the first entry that is strictly worse
  assign behind   = is_bid ? (price_r < new_price) : (price_r > new_price);
  assign ins_here = up_ins | ~occ | behind;
  assign my_hit   = occ & (id_r == new_id);
  assign hit_here = up_hit | my_hit;

  always_comb begin
    price_nxt = price_r;
    qty_nxt   = qty_r;
    id_nxt    = id_r;
    if (cmd.pop || (cmd.del && hit_here)) begin
      price_nxt = next_price;
      qty_nxt   = next_qty;
      id_nxt    = next_id;
    end else if (cmd.ins && ins_here) begin
      if (up_ins) begin
        price_nxt = prev_price;
        qty_nxt   = prev_qty;
        id_nxt    = prev_id;
      end else begin
        price_nxt = new_price;
        qty_nxt   = new_qty;
        id_nxt    = new_id;
      end
    end else if (cmd.dec && is_head) begin
      qty_nxt = qty_r - dec_qty;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
    id_r    <= id_nxt;
  end
endmodule

[rtl/core/lobm_side.sv]
// One side of the book: a sorted row of entry cells and a fill count
module lobm_side #(
  parameter int DEPTH = 32,
  parameter int PW    = 16,
  parameter int QW    = 20,
  parameter int IW    = 32,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                is_bid,
  input  lobm_pkg::side_cmd_t cmd,
  input  logic [PW-1:0]       new_price,
  input  logic [QW-1:0]       new_qty,
  input  logic [IW-1:0]       new_id,
  input  logic [QW-1:0]       dec_qty,
  output logic [CW-1:0]       count_r,
  output logic                found,
  output logic [PW-1:0]       head_price,
  output logic [QW-1:0]       head_qty,
  output logic [IW-1:0]       head_id
);
  logic [PW-1:0] pr [DEPTH];
  logic [QW-1:0] qt [DEPTH];
  logic [IW-1:0] ow [DEPTH];
  logic [DEPTH-1:0] ins_v, hit_v;
  logic [CW-1:0] count_nxt;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic occ;
    assign occ = (CW'(g) < count_r);
    lobm_cell #(.PW(PW), .QW(QW), .IW(IW)) u_cell (
      .clk        (clk),
      .is_bid     (is_bid),
      .cmd        (cmd),
      .occ        (occ),
      .up_ins     ((g == 0) ? 1'b0 : ins_v[(g == 0) ? 0 : g-1]),
      .up_hit     ((g == 0) ? 1'b0 : hit_v[(g == 0) ? 0 : g-1]),
      .prev_price ((g == 0) ? new_price : pr[(g == 0) ? 0 : g-1]),
      .prev_qty   ((g == 0) ? new_qty : qt[(g == 0) ? 0 : g-1]),
      .prev_id    ((g == 0) ? new_id : ow[(g == 0) ? 0 : g-1]),
      .next_price (pr[(g == DEPTH-1) ? g : g+1]),
      .next_qty   (qt[(g == DEPTH-1) ? g : g+1]),
      .next_id    (ow[(g == DEPTH-1) ? g : g+1]),
      .new_price  (new_price),
      .new_qty    (new_qty),
      .new_id     (new_id),
      .dec_qty    (dec_qty),
      .is_head    (g == 0),
      .ins_here   (ins_v[g]),
      .hit_here   (hit_v[g]),
      .price_r    (pr[g]),
      .qty_r      (qt[g]),
      .id_r       (ow[g])
    );
  end

  assign found      = hit_v[DEPTH-1];
  assign head_price = pr[0];
  assign head_qty   = qt[0];
  assign head_id    = ow[0];

  always_comb begin
    count_nxt = count_r;
    if (cmd.pop || (cmd.del && found)) count_nxt = count_r - CW'(1);
    else if (cmd.ins)                  count_nxt = count_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end
endmodule

[rtl/core/limit_order_book_matcher_unit.sv]
// Top level: price-time priority order book, sequencer and output register
// One item at a time; its results come out in order, trades first, then one summary
// with tlast set. The item is accepted in idle. A cancel searches both rows, then
// loads its summary, and only after that can a new item be accepted.
// An order matches one head entry per cycle against the opposite row of cells while
// the output register is free; it then sees the sweep end, rests or drops a remainder
// when one is left, and loads its summary. An unknown mode goes straight to its summary.
// The sequencer stalls while a result waits in the output register and out_tready is
// low.
// Each side is a row of SIDE_DEPTH cells that shift one place per pop, insert
// or removal; the fill count alone marks which cells hold entries.
`include "assert_macros.svh"
module limit_order_book_matcher_unit #(
  parameter int SIDE_DEPTH = 32,
  parameter int PRICE_BITS = 16,
  parameter int QTY_BITS   = 20,
  parameter int ID_BITS    = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [1:0] in_tuser,  // mode
  // side, limit_price, quantity, cancel_id, zero padding
  input  logic [((1+PRICE_BITS+QTY_BITS+ID_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // buyer_id, seller_id, trade_price, trade_qty, new_order_id, status, zero pad
  output logic [((3*ID_BITS+PRICE_BITS+QTY_BITS+3+7)/8)*8-1:0] out_tdata,
  output logic out_tuser,  // kind
  output logic out_tlast
);
  localparam int CW  = $clog2(SIDE_DEPTH + 1);
  localparam int ODW = ((3*ID_BITS+PRICE_BITS+QTY_BITS+3+7)/8)*8;
  localparam int P0  = 1;
  localparam int Q0  = P0 + PRICE_BITS;
  localparam int C0  = Q0 + QTY_BITS;

  lobm_pkg::fsm_t state_r, state_nxt;
  logic [1:0]          mode_r;
  logic                sell_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0] rem_r, rem_nxt;
  logic [ID_BITS-1:0]  cid_r, id_r, id_nxt, next_id_r, next_id_nxt;
  logic [2:0]          status_r, status_nxt;
  logic [1:0]          mode_nxt;
  logic                sell_nxt;
  logic [PRICE_BITS-1:0] price_nxt;
  logic [ID_BITS-1:0]  cid_nxt;

  logic                ov_r, ov_nxt, okind_r, okind_nxt, olast_r, olast_nxt;
  logic [ODW-1:0]      odata_r, odata_nxt;

  lobm_pkg::side_cmd_t bcmd, acmd;
  logic [CW-1:0]       bcnt, acnt;
  logic                bfound, afound;
  logic [PRICE_BITS-1:0] bhp, ahp, side_price;
  logic [QTY_BITS-1:0] bhq, ahq, tq;
  logic [ID_BITS-1:0]  bhi, ahi, side_id;
  logic [PRICE_BITS-1:0] ohp;
  logic [QTY_BITS-1:0] ohq;
  logic [ID_BITS-1:0]  ohi;
  logic [CW-1:0]       ocnt, scnt;
  logic                out_free, crosses;

  assign side_price = price_r;
  assign side_id    = (state_r == lobm_pkg::S_CANCEL) ? cid_r : id_r;

  lobm_side #(.DEPTH(SIDE_DEPTH), .PW(PRICE_BITS), .QW(QTY_BITS), .IW(ID_BITS)) u_bid (
    .clk(clk), .rst_n(rst_n), .is_bid(1'b1), .cmd(bcmd),
    .new_price(side_price), .new_qty(rem_r), .new_id(side_id), .dec_qty(tq),
    .count_r(bcnt), .found(bfound), .head_price(bhp), .head_qty(bhq), .head_id(bhi)
  );
  lobm_side #(.DEPTH(SIDE_DEPTH), .PW(PRICE_BITS), .QW(QTY_BITS), .IW(ID_BITS)) u_ask (
    .clk(clk), .rst_n(rst_n), .is_bid(1'b0), .cmd(acmd),
    .new_price(side_price), .new_qty(rem_r), .new_id(side_id), .dec_qty(tq),
    .count_r(acnt), .found(afound), .head_price(ahp), .head_qty(ahq), .head_id(ahi)
  );

  assign ohp  = sell_r ? bhp : ahp;
  assign ohq  = sell_r ? bhq : ahq;
  assign ohi  = sell_r ? bhi : ahi;
  assign ocnt = sell_r ? bcnt : acnt;
  assign scnt = sell_r ? acnt : bcnt;
  assign tq   = (rem_r < ohq) ? rem_r : ohq;
  assign crosses = (mode_r != lobm_pkg::MODE_LIMIT) ||
                   (sell_r ? (price_r <= ohp) : (price_r >= ohp));
  assign out_free  = ~ov_r | out_tready;
  assign in_tready = (state_r == lobm_pkg::S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    sell_nxt    = sell_r;
    price_nxt   = price_r;
    rem_nxt     = rem_r;
    cid_nxt     = cid_r;
    id_nxt      = id_r;
    next_id_nxt = next_id_r;
    status_nxt  = status_r;
    ov_nxt      = ov_r & ~out_tready;
    okind_nxt   = okind_r;
    olast_nxt   = olast_r;
    odata_nxt   = odata_r;
    bcmd        = '0;
    acmd        = '0;
    unique case (state_r)
      lobm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          sell_nxt  = in_tdata[0];
          price_nxt = in_tdata[P0 +: PRICE_BITS];
          rem_nxt   = in_tdata[Q0 +: QTY_BITS];
          cid_nxt   = in_tdata[C0 +: ID_BITS];
          id_nxt    = '0;
          priority if (in_tuser == lobm_pkg::MODE_CANCEL) begin
            state_nxt = lobm_pkg::S_CANCEL;
          end else if (in_tuser == lobm_pkg::MODE_LIMIT ||
                       in_tuser == lobm_pkg::MODE_MARKET) begin
            id_nxt      = next_id_r;
            next_id_nxt = next_id_r + ID_BITS'(1);
            state_nxt   = lobm_pkg::S_MATCH;
          end else begin
            status_nxt = lobm_pkg::ST_NOT_FOUND;
            state_nxt  = lobm_pkg::S_SUMMARY;
          end
        end
      end
      lobm_pkg::S_CANCEL: begin
        // bids take precedence; asks only when no bid holds the id
        if (bfound)      bcmd.del = 1'b1;
        else if (afound) acmd.del = 1'b1;
        status_nxt = (bfound || afound) ? lobm_pkg::ST_CANCELLED : lobm_pkg::ST_NOT_FOUND;
        state_nxt  = lobm_pkg::S_SUMMARY;
      end
      lobm_pkg::S_MATCH: begin
        if (rem_r == '0) begin
          status_nxt = lobm_pkg::ST_FILLED;
          state_nxt  = lobm_pkg::S_SUMMARY;
        end else if (ocnt == '0 || !crosses) begin
          state_nxt = lobm_pkg::S_REST;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = 1'b0;
          olast_nxt = 1'b0;
          odata_nxt = ODW'({3'd0, id_r, tq, ohp,
                            (sell_r ? id_r : ohi), (sell_r ? ohi : id_r)});
          rem_nxt = rem_r - tq;
          if (tq == ohq) begin
            if (sell_r) bcmd.pop = 1'b1; else acmd.pop = 1'b1;
          end else begin
            if (sell_r) bcmd.dec = 1'b1; else acmd.dec = 1'b1;
          end
        end
      end
      lobm_pkg::S_REST: begin
        if (mode_r != lobm_pkg::MODE_LIMIT) begin
          status_nxt = lobm_pkg::ST_MKT_DROP;
        end else if (scnt >= CW'(SIDE_DEPTH)) begin
          status_nxt = lobm_pkg::ST_FULL_DROP;
        end else begin
          status_nxt = lobm_pkg::ST_RESTED;
          if (sell_r) acmd.ins = 1'b1; else bcmd.ins = 1'b1;
        end
        state_nxt = lobm_pkg::S_SUMMARY;
      end
      lobm_pkg::S_SUMMARY: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = 1'b1;
          olast_nxt = 1'b1;
          odata_nxt = ODW'({status_r, id_r, QTY_BITS'(0), PRICE_BITS'(0),
                            ID_BITS'(0), ID_BITS'(0)});
          state_nxt = lobm_pkg::S_IDLE;
        end
      end
      default: state_nxt = lobm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lobm_pkg::S_IDLE;
      next_id_r <= ID_BITS'(1);
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      next_id_r <= next_id_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    sell_r   <= sell_nxt;
    price_r  <= price_nxt;
    rem_r    <= rem_nxt;
    cid_r    <= cid_nxt;
    id_r     <= id_nxt;
    status_r <= status_nxt;
    okind_r  <= okind_nxt;
    olast_r  <= olast_nxt;
    odata_r  <= odata_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  `AST_IMPL(a_cnt_bid, clk, rst_n, 1'b1, bcnt <= CW'(SIDE_DEPTH))
  `AST_IMPL(a_cnt_ask, clk, rst_n, 1'b1, acnt <= CW'(SIDE_DEPTH))
  `AST_IMPL(a_last_kind, clk, rst_n, out_tvalid, out_tlast == out_tuser)
  `AST_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

[tb/limit_order_book_matcher_unit_tb.sv]
// Testbench of the order book matcher: predicts trades and summaries, checks each result
`timescale 1ns / 100ps
module limit_order_book_matcher_unit_tb;
  localparam int DEPTH = 32;
  localparam int IN_W  = ((1+16+20+32+7)/8)*8;
  localparam int OUT_W = ((3*32+16+20+3+7)/8)*8;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic        kind;
    logic [31:0] buyer;
    logic [31:0] seller;
    logic [15:0] price;
    logic [19:0] qty;
    logic [31:0] oid;
    logic [2:0]  status;
    logic        last;
  } book_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  limit_order_book_matcher_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted book
  logic [15:0] bid_px[DEPTH], ask_px[DEPTH];
  logic [19:0] bid_q[DEPTH], ask_q[DEPTH];
  logic [31:0] bid_id[DEPTH], ask_id[DEPTH];
  int bid_n = 0, ask_n = 0;
  logic [31:0] id_next = 32'd1;

  book_result_t pending_results[$];
  int errors = 0;
  int n_orders = 0, n_trades = 0, n_results = 0;
  int quiet = 0;
  bit out_stalls = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_result(logic kind, logic [31:0] b, logic [31:0] s,
                                      logic [15:0] p, logic [19:0] q, logic [31:0] oid,
                                      logic [2:0] st, logic last);
    book_result_t r;
    r.kind = kind; r.buyer = b; r.seller = s; r.price = p; r.qty = q;
    r.oid = oid; r.status = st; r.last = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void drop_bid(int at);
    for (int i = at; i < bid_n - 1; i++) begin
      bid_px[i] = bid_px[i+1]; bid_q[i] = bid_q[i+1]; bid_id[i] = bid_id[i+1];
    end
    bid_n--;
  endfunction

  function automatic void drop_ask(int at);
    for (int i = at; i < ask_n - 1; i++) begin
      ask_px[i] = ask_px[i+1]; ask_q[i] = ask_q[i+1]; ask_id[i] = ask_id[i+1];
    end
    ask_n--;
  endfunction

  function automatic void predict_order(logic [1:0] mode, logic sell, logic [15:0] px,
                                        logic [19:0] qty, logic [31:0] cid);
    logic [31:0] oid;
    logic [19:0] rem, tq;
    logic [2:0] st;
    bit hit, is_limit;
    int k, pos;
    if (mode == lobm_pkg::MODE_CANCEL) begin
      hit = 0;
      for (int i = 0; i < bid_n && !hit; i++)
        if (bid_id[i] == cid) begin drop_bid(i); hit = 1; end
      for (int i = 0; i < ask_n && !hit; i++)
        if (ask_id[i] == cid) begin drop_ask(i); hit = 1; end
      push_result(1'b1, '0, '0, '0, '0, '0,
                  hit ? lobm_pkg::ST_CANCELLED : lobm_pkg::ST_NOT_FOUND, 1'b1);
      return;
    end
    if (mode == lobm_pkg::MODE_RESERVED) begin
      push_result(1'b1, '0, '0, '0, '0, '0, lobm_pkg::ST_NOT_FOUND, 1'b1);
      return;
    end
    is_limit = (mode == lobm_pkg::MODE_LIMIT);
    oid = id_next;
    id_next = id_next + 1;
    rem = qty;
    k = 0;
    if (sell) begin
      while (rem > 0 && bid_n > 0 && k < DEPTH) begin
        if (is_limit && px > bid_px[0]) break;
        tq = rem < bid_q[0] ? rem : bid_q[0];
        push_result(1'b0, bid_id[0], oid, bid_px[0], tq, oid, 3'd0, 1'b0);
        k++; rem -= tq; bid_q[0] -= tq;
        if (bid_q[0] == 0) drop_bid(0);
      end
    end else begin
      while (rem > 0 && ask_n > 0 && k < DEPTH) begin
        if (is_limit && px < ask_px[0]) break;
        tq = rem < ask_q[0] ? rem : ask_q[0];
        push_result(1'b0, oid, ask_id[0], ask_px[0], tq, oid, 3'd0, 1'b0);
        k++; rem -= tq; ask_q[0] -= tq;
        if (ask_q[0] == 0) drop_ask(0);
      end
    end
    n_trades += k;
    if (rem == 0) st = lobm_pkg::ST_FILLED;
    else if (!is_limit) st = lobm_pkg::ST_MKT_DROP;
    else if (sell ? ask_n >= DEPTH : bid_n >= DEPTH) st = lobm_pkg::ST_FULL_DROP;
    else begin
      st = lobm_pkg::ST_RESTED;
      if (sell) begin
        pos = 0;
        while (pos < ask_n && ask_px[pos] <= px) pos++;
        for (int i = ask_n; i > pos; i--) begin
          ask_px[i] = ask_px[i-1]; ask_q[i] = ask_q[i-1]; ask_id[i] = ask_id[i-1];
        end
        ask_px[pos] = px; ask_q[pos] = rem; ask_id[pos] = oid; ask_n++;
      end else begin
        pos = 0;
        while (pos < bid_n && bid_px[pos] >= px) pos++;
        for (int i = bid_n; i > pos; i--) begin
          bid_px[i] = bid_px[i-1]; bid_q[i] = bid_q[i-1]; bid_id[i] = bid_id[i-1];
        end
        bid_px[pos] = px; bid_q[pos] = rem; bid_id[pos] = oid; bid_n++;
      end
    end
    push_result(1'b1, '0, '0, '0, '0, oid, st, 1'b1);
  endfunction

  task automatic send_order(logic [1:0] mode, logic sell, logic [15:0] px,
                            logic [19:0] qty, logic [31:0] cid);
    int g;
    g = gap_len();
    // drop valid only when a gap follows, so back-to-back items keep it high
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tuser <= mode;
    in_tdata <= {3'b000, cid, qty, px, sell};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_order(mode, sell, px, qty, cid);
    n_orders++;
  endtask

  // output side: random stalls, compare against oldest prediction
  always @(posedge clk) begin
    book_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
      end else begin
        e = pending_results[0];
        pending_results.delete(0);
        if ({out_tuser, out_tlast, out_tdata[134:0]} !==
            {e.kind, e.last, e.status, e.oid, e.qty, e.price, e.seller, e.buyer}) begin
          errors++;
          $display("%0t: mismatch expected kind %0d buyer %0d seller %0d px %0d qty %0d",
                   $time, e.kind, e.buyer, e.seller, e.price, e.qty);
          $display("%0t:          expected id %0d st %0d last %0d",
                   $time, e.oid, e.status, e.last);
          $display("%0t:          actual kind %0d buyer %0d seller %0d px %0d qty %0d",
                   $time, out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[79:64],
                   out_tdata[99:80]);
          $display("%0t:          actual id %0d st %0d last %0d",
                   $time, out_tdata[131:100], out_tdata[134:132], out_tlast);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!out_stalls) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_order(lobm_pkg::MODE_LIMIT, 1'b0, 16'd0, 20'd0, 32'd0);        // zero quantity
    send_order(lobm_pkg::MODE_LIMIT, 1'b1, 16'hFFFF, 20'hFFFFF, 32'hFFFFFFFF);
    send_order(lobm_pkg::MODE_LIMIT, 1'b0, 16'd100, 20'd5, 32'd0);
    send_order(lobm_pkg::MODE_LIMIT, 1'b0, 16'd100, 20'd7, 32'd0);     // queue behind
    send_order(lobm_pkg::MODE_LIMIT, 1'b1, 16'd90, 20'd9, 32'd0);      // sweep two bids
    send_order(lobm_pkg::MODE_MARKET, 1'b1, 16'd0, 20'd50, 32'd0);     // rest dropped
    send_order(lobm_pkg::MODE_MARKET, 1'b0, 16'hFFFF, 20'd3, 32'd0);
    send_order(lobm_pkg::MODE_MARKET, 1'b0, 16'd0, 20'd0, 32'd0);
    send_order(lobm_pkg::MODE_CANCEL, 1'b0, 16'd0, 20'd0, 32'd2);      // ask found
    send_order(lobm_pkg::MODE_CANCEL, 1'b1, 16'hFFFF, 20'hFFFFF, 32'hFFFFFFFF);
    send_order(lobm_pkg::MODE_RESERVED, 1'b1, 16'hFFFF, 20'hFFFFF, 32'hFFFFFFFF);
    send_order(lobm_pkg::MODE_LIMIT, 1'b0, 16'd0, 20'd1, 32'd0);
    send_order(lobm_pkg::MODE_CANCEL, 1'b0, 16'd0, 20'd0, id_next - 1); // bid found
    wait_drained();
  endtask

  task automatic test_book_full();
    // fill the bid side, then overflow it; finally sweep with one big sell
    out_stalls = 1'b0;
    for (int i = 0; i < DEPTH + 2; i++)
      send_order(lobm_pkg::MODE_LIMIT, 1'b0, 16'(1000 + $urandom_range(0, 5)),
                 20'($urandom_range(1, 4)), 32'd0);
    out_stalls = 1'b1;
    send_order(lobm_pkg::MODE_MARKET, 1'b1, 16'd0, 20'hFFFFF, 32'd0);
    wait_drained();
  endtask

  task automatic test_random();
    logic [1:0] mode;
    logic [31:0] cid;
    int r;
    for (int i = 0; i < 240; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) mode = lobm_pkg::MODE_LIMIT;
      else if (r < 72) mode = lobm_pkg::MODE_MARKET;
      else if (r < 97) mode = lobm_pkg::MODE_CANCEL;
      else mode = lobm_pkg::MODE_RESERVED;
      if ($urandom_range(0, 9) < 8)
        cid = (id_next > 40) ? id_next - 32'($urandom_range(1, 40))
                             : 32'($urandom_range(0, 40));
      else
        cid = $urandom;
      if ($urandom_range(0, 19) == 0)
        send_order(mode, 1'($urandom), 16'($urandom), 20'($urandom), cid);
      else
        send_order(mode, 1'($urandom), 16'(500 + $urandom_range(0, 20)),
                   20'($urandom_range(0, 60)), cid);
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_book_full();
    test_random();
    repeat (20) @(posedge clk);
    $display("Sent %0d orders and cancels, checked %0d results including %0d trades.",
             n_orders, n_results, n_trades);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
